[rtl/channel_slot_table_defines.svh]
// Assertion macros for the channel slot table RTL.
`ifndef CHANNEL_SLOT_TABLE_DEFINES_SVH
`define CHANNEL_SLOT_TABLE_DEFINES_SVH

// Check on the rising clock edge, skipped while reset is high.
`define CST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on the rising clock edge, reset included.
`define CST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cst_pkg.sv]
// Types and codes shared by the channel slot table modules.
package cst_pkg;

  localparam int CMD_W    = 2;
  localparam int DEV_W    = 5;
  localparam int SA_W     = 5;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLAIM  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CHANNEL = 2'd2;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [SA_W-1:0]  sa;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [DEV_W-1:0] dev;
    logic [SA_W-1:0]  sa;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                fresh;
  } res_t;

endpackage

[rtl/cst_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module cst_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cst_seq.sv]
// Slot scan sequencer: one shared entry comparator stepped over the slot RAM.
`include "channel_slot_table_defines.svh"

module cst_seq import cst_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  input  logic res_ready,
  output logic busy,
  output logic done,
  output res_t res
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0]    SLOTS_C = CW'(SLOTS);
  localparam logic [IDX_W:0]   SLOTS_I = (IDX_W + 1)'(SLOTS);

  typedef enum logic [2:0] {IDLE, SCAN, DECIDE, CLAIM, DONE} state_t;

  state_t         state;
  req_t           req_q;
  logic [CW-1:0]  cnt;
  logic           rd_pend;
  logic [IW-1:0]  rd_idx;
  logic           match_hit;
  logic [IW-1:0]  match_idx;
  logic           free_hit;
  logic [IW-1:0]  free_idx;
  logic [SLOTS-1:0] vld;
  res_t           res_q;

  logic           we;
  logic [IW-1:0]  waddr;
  entry_t         wdata;
  logic [IW-1:0]  raddr;
  entry_t         rdata;
  entry_t         cur;
  logic           is_match;
  logic           is_free;
  logic           idx_ok;
  logic           set_vld;
  logic           clr_vld;
  res_t           res_next;

  cst_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign raddr    = (state == IDLE) ? req.idx[IW-1:0] : cnt[IW-1:0];
  assign cur      = vld[rd_idx] ? rdata : '0;
  assign is_match = (cur.dev == req_q.dev) && (cur.sa == req_q.sa);
  assign is_free  = (cur.dev == '0);
  assign idx_ok   = ({1'b0, req.idx} < SLOTS_I);
  assign wdata    = '{dev: req_q.dev, sa: req_q.sa};

  always_comb begin
    we       = 1'b0;
    set_vld  = 1'b0;
    clr_vld  = 1'b0;
    waddr    = free_idx;
    res_next = '{status: ST_NO_CHANNEL, slot: '0, fresh: 1'b0};
    if (state == DECIDE) begin
      unique case (req_q.cmd)
        CMD_LOOKUP: begin
          if (match_hit) begin
            res_next = '{status: ST_OK, slot: SLOT_W'(match_idx), fresh: 1'b0};
          end else begin
            res_next.status = ST_NO_MATCH;
          end
        end
        CMD_ALLOC: begin
          if (match_hit) begin
            res_next = '{status: ST_OK, slot: SLOT_W'(match_idx), fresh: 1'b0};
          end else if (free_hit) begin
            we       = 1'b1;
            set_vld  = 1'b1;
            res_next = '{status: ST_OK, slot: SLOT_W'(free_idx), fresh: 1'b1};
          end
        end
        CMD_FREE: begin
          if (match_hit) begin
            clr_vld  = 1'b1;
            waddr    = match_idx;
            res_next = '{status: ST_OK, slot: SLOT_W'(match_idx), fresh: 1'b0};
          end else begin
            res_next.status = ST_NO_MATCH;
          end
        end
        default: begin
          res_next.status = ST_NO_CHANNEL;
        end
      endcase
    end else if (state == CLAIM) begin
      waddr = rd_idx;
      if (is_free) begin
        we       = 1'b1;
        set_vld  = 1'b1;
        res_next = '{status: ST_OK, slot: SLOT_W'(rd_idx), fresh: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      vld     <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            req_q     <= req;
            cnt       <= '0;
            rd_pend   <= 1'b0;
            match_hit <= 1'b0;
            free_hit  <= 1'b0;
            if (req.cmd == CMD_CLAIM) begin
              if (idx_ok) begin
                rd_idx <= req.idx[IW-1:0];
                state  <= CLAIM;
              end else begin
                res_q <= '{status: ST_NO_CHANNEL, slot: '0, fresh: 1'b0};
                state <= DONE;
              end
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (cnt < SLOTS_C) begin
            cnt     <= CW'(cnt + 1'b1);
            rd_idx  <= cnt[IW-1:0];
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            if (is_match && !match_hit) begin
              match_hit <= 1'b1;
              match_idx <= rd_idx;
            end
            if (is_free && !free_hit) begin
              free_hit <= 1'b1;
              free_idx <= rd_idx;
            end
            if (cnt == SLOTS_C) begin
              state <= DECIDE;
            end
          end
        end
        DECIDE, CLAIM: begin
          res_q <= res_next;
          if (set_vld) begin
            vld[waddr] <= 1'b1;
          end
          if (clr_vld) begin
            vld[waddr] <= 1'b0;
          end
          state <= DONE;
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign busy = (state != IDLE);
  assign done = (state == DONE);
  assign res  = res_q;

  `CST_ASSERT(a_fresh_is_ok, done |-> !res_q.fresh || res_q.status == ST_OK, "fresh without ok")
  `CST_ASSERT(a_fail_slot_zero, done && res_q.status != ST_OK |-> res_q.slot == '0, "fail slot")
  `CST_ASSERT(a_start_busy, start |=> busy, "start did not make the sequencer busy")
  `CST_ASSERT(a_hold_result, done && !res_ready |=> done && $stable(res_q), "result lost")

endmodule

[rtl/channel_slot_table.sv]
// Top level of the channel slot table: request handshake, sequencer and result register.
//
// Usage:
//   Request channel: req_valid/req_stall carry cmd, device_number,
//   secondary_address and slot_index. A transaction is taken at a clock
//   edge with req_valid high and req_stall low. req_stall stays high while
//   a command is in work, so one command is handled at a time.
//   Response channel: rsp_valid/rsp_stall carry status, slot and
//   newly_allocated, one response per request, in order.
//   Lookup, get-or-allocate and free scan the slot RAM one entry per cycle,
//   and a new request is taken only after the last result has moved to
//   the output register. Claim reads the named slot only, and answers with
//   no channel when the slot number is out of range.
//   The response sits in an output register; while rsp_stall holds it, the
//   next finished result waits in the sequencer and requests stall.
//   Reset marks every slot free at once through per-slot valid bits and
//   drops any pending response; no clearing pass is needed.
module channel_slot_table import cst_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [DEV_W-1:0]    device_number,
  input  logic [SA_W-1:0]     secondary_address,
  input  logic [IDX_W-1:0]    slot_index,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic                newly_allocated
);

  logic busy;
  logic done;
  logic start;
  logic res_ready;
  req_t req;
  res_t res;

  assign req_stall = busy;
  assign start     = req_valid && !busy;
  assign res_ready = !rsp_valid || !rsp_stall;
  assign req       = '{cmd: cmd, dev: device_number, sa: secondary_address, idx: slot_index};

  cst_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .res_ready(res_ready),
    .busy     (busy),
    .done     (done),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_ready) begin
      status          <= res.status;
      slot            <= res.slot;
      newly_allocated <= res.fresh;
    end
  end

endmodule
